>>> hdl/matrix_inverse_4x4_core_defines.svh
// assertion macros shared by the rtl
`ifndef MATRIX_INVERSE_4X4_CORE_DEFINES_SVH
`define MATRIX_INVERSE_4X4_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MI4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MI4_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MI4_ASSERT(lbl, prop, msg)
`define MI4_ASSERT_NR(lbl, prop, msg)
`endif
`endif

>>> hdl/mi4_pkg.sv
`default_nettype none
package mi4_pkg;

  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int DIGIT_BITS        = 8;
  localparam int TERMS             = 6;

  // column order of each 3x3 permutation term, s0 s1 s2
  localparam logic [5:0] PERM_TAB [TERMS] = '{
    6'b00_01_10, 6'b01_10_00, 6'b10_00_01,
    6'b00_10_01, 6'b01_00_10, 6'b10_01_00
  };
  // odd permutations subtract
  localparam logic [TERMS-1:0] PERM_NEG = 6'b111000;

  // accumulator width for products and sums of an element width
  function automatic int acc_width(input int w);
    return 4 * w + 4;
  endfunction

  // k-th index of 0..3 skipping d
  function automatic logic [1:0] skip_idx(input logic [1:0] d, input logic [1:0] k);
    return (k >= d) ? k + 2'd1 : k;
  endfunction

endpackage
`default_nettype wire

>>> hdl/matrix_inverse_4x4_core.sv
// 4x4 inverse by cofactors, signed fixed point, one element request per cycle while loading
// after the sixteenth element the cofactors, determinant and quotients are computed by the
//   shared digit multiplier and the bit-serial divider, both fed from the element and
//   cofactor memories
// a new matrix is loaded only after the last element of the previous inverse is emitted
// reset: synchronous, clears the sequencer, load count and output valid; memories keep contents
`default_nettype none
`include "matrix_inverse_4x4_core_defines.svh"
module matrix_inverse_4x4_core #(
  parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic element_valid,
  output logic element_stall,
  input  wire logic signed [ELEMENT_WIDTH-1:0] element,
  output logic result_valid,
  input  wire logic result_stall,
  output logic signed [ELEMENT_WIDTH-1:0] inverse_element,
  output logic [3:0] position,
  output logic singular,
  output logic saturated,
  output logic last
);
  import mi4_pkg::*;

  localparam int W  = ELEMENT_WIDTH;
  localparam int AW = acc_width(ELEMENT_WIDTH);
  localparam logic [W:0] HALF = {2'b01, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_FIX = W'(1) << FRACTION_BITS;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [4:0] {
    S_LOAD, S_RD0, S_RD1, S_RD2, S_MUL1, S_MUL2, S_CSTORE,
    S_DRD, S_DLD, S_DMUL, S_DCHK, S_ORD, S_OLD, S_DIV, S_EMIT
  } state_t;

  state_t state;
  logic [3:0] load_count;
  logic [3:0] pos;
  logic [2:0] term;
  logic signed [W-1:0] e0_hold;
  logic signed [AW-1:0] cof_acc;
  logic signed [AW-1:0] det;
  logic [AW-1:0] dmag;
  logic dneg;
  logic sing_r;
  logic q_neg;
  logic [W-1:0] res_val;
  logic res_sat;

  // element memory
  logic signed [W-1:0] mat_mem [16];
  logic signed [W-1:0] mat_rdata;
  logic [3:0] mat_raddr;
  logic mat_re;
  logic accept;

  // cofactor memory
  logic signed [AW-1:0] cof_mem [16];
  logic signed [AW-1:0] cof_rdata;
  logic [3:0] cof_raddr;
  logic cof_re;
  logic cof_we;
  logic signed [AW-1:0] cof_wdata;

  logic mul_start, mul_busy, mul_done;
  logic signed [AW-1:0] mul_mcand;
  logic signed [W-1:0] mul_mplr;
  logic [AW-1:0] mul_prod;

  logic div_start, div_done, quot_big;
  logic [W:0] quot;
  logic [AW-1:0] num_mag;

  logic [1:0] dr, dc, s0, s1, s2;
  logic [W-1:0] q_val;
  logic q_sat;

  assign element_stall = (state != S_LOAD);
  assign accept = element_valid && !element_stall;

  always_ff @(posedge clk) begin
    if (accept) mat_mem[load_count] <= element;
    if (mat_re) mat_rdata <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (cof_we) cof_mem[pos] <= cof_wdata;
    if (cof_re) cof_rdata <= cof_mem[cof_raddr];
  end

  always_comb begin
    dr = pos[3:2];
    dc = pos[1:0];
    s0 = PERM_TAB[term][5:4];
    s1 = PERM_TAB[term][3:2];
    s2 = PERM_TAB[term][1:0];
    mat_re = 1'b0;
    mat_raddr = '0;
    cof_re = 1'b0;
    cof_raddr = pos;
    cof_we = (state == S_CSTORE);
    cof_wdata = (dr[0] ^ dc[0]) ? -cof_acc : cof_acc;
    mul_start = 1'b0;
    mul_mcand = AW'(e0_hold);
    mul_mplr = mat_rdata;
    div_start = (state == S_OLD);
    num_mag = cof_rdata[AW-1] ? AW'(-cof_rdata) : AW'(cof_rdata);
    unique case (state)
      S_RD0: begin
        mat_re = 1'b1;
        mat_raddr = {skip_idx(dc, s0), skip_idx(dr, 2'd0)};
      end
      S_RD1: begin
        mat_re = 1'b1;
        mat_raddr = {skip_idx(dc, s1), skip_idx(dr, 2'd1)};
      end
      S_RD2: begin
        mat_re = 1'b1;
        mat_raddr = {skip_idx(dc, s2), skip_idx(dr, 2'd2)};
        mul_start = 1'b1;
      end
      S_MUL1: begin
        // second product: pair product times the third element
        mul_start = mul_done;
        mul_mcand = mul_prod;
      end
      S_DRD: begin
        mat_re = 1'b1;
        mat_raddr = {2'b00, pos[1:0]};
        cof_re = 1'b1;
        cof_raddr = {pos[1:0], 2'b00};
      end
      S_DLD: begin
        mul_start = 1'b1;
        mul_mcand = cof_rdata;
      end
      S_ORD: cof_re = !sing_r;
      default: ;
    endcase
  end

  always_comb begin
    if (q_neg) begin
      q_sat = quot_big || (quot > HALF);
      q_val = q_sat ? MAX_NEG : W'(~quot + 1'b1);
    end else begin
      q_sat = quot_big || (quot >= HALF);
      q_val = q_sat ? MAX_POS : quot[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_count <= '0;
      result_valid <= 1'b0;
    end else begin
      // emit state sets valid itself, so the drop only happens elsewhere
      if (result_valid && !result_stall && state != S_EMIT) result_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            load_count <= load_count + 1'b1;
            if (load_count == 4'hf) begin
              pos <= '0;
              term <= '0;
              cof_acc <= '0;
              state <= S_RD0;
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          e0_hold <= mat_rdata;
          state <= S_RD2;
        end
        S_RD2: state <= S_MUL1;
        S_MUL1: if (mul_done) state <= S_MUL2;
        S_MUL2: begin
          if (mul_done) begin
            cof_acc <= PERM_NEG[term] ? cof_acc - $signed(mul_prod)
                                      : cof_acc + $signed(mul_prod);
            if (term == 3'(TERMS - 1)) begin
              state <= S_CSTORE;
            end else begin
              term <= term + 1'b1;
              state <= S_RD0;
            end
          end
        end
        S_CSTORE: begin
          cof_acc <= '0;
          term <= '0;
          pos <= pos + 1'b1;
          if (pos == 4'hf) begin
            det <= '0;
            state <= S_DRD;
          end else begin
            state <= S_RD0;
          end
        end
        S_DRD: state <= S_DLD;
        S_DLD: state <= S_DMUL;
        S_DMUL: begin
          if (mul_done) begin
            det <= det + $signed(mul_prod);
            if (pos[1:0] == 2'd3) begin
              pos <= '0;
              state <= S_DCHK;
            end else begin
              pos <= pos + 1'b1;
              state <= S_DRD;
            end
          end
        end
        S_DCHK: begin
          sing_r <= (det == '0);
          dneg <= det[AW-1];
          dmag <= det[AW-1] ? AW'(-det) : AW'(det);
          state <= S_ORD;
        end
        S_ORD: begin
          if (sing_r) begin
            res_val <= (pos[1:0] == pos[3:2]) ? ONE_FIX : '0;
            res_sat <= 1'b0;
            state <= S_EMIT;
          end else begin
            state <= S_OLD;
          end
        end
        S_OLD: begin
          q_neg <= cof_rdata[AW-1] ^ dneg;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_val <= q_val;
            res_sat <= q_sat;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            inverse_element <= res_val;
            position <= pos;
            singular <= sing_r;
            saturated <= res_sat;
            last <= (pos == 4'hf);
            pos <= pos + 1'b1;
            state <= (pos == 4'hf) ? S_LOAD : S_ORD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  mi4_mul #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .mcand_in(mul_mcand),
    .mplr_in(mul_mplr),
    .busy(mul_busy),
    .done(mul_done),
    .prod(mul_prod)
  );

  mi4_div #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num_mag(num_mag),
    .den_mag(dmag),
    .done(div_done),
    .quot(quot),
    .quot_big(quot_big)
  );

  `MI4_ASSERT_NR(a_reset_clears_out, rst |=> !result_valid, "output valid after reset")
  `MI4_ASSERT(a_singular_clean, result_valid && singular |-> !saturated, "singular saturated")
  `MI4_ASSERT(a_mul_free, mul_start |-> !mul_busy, "multiplier started while busy")
  `MI4_ASSERT(a_last_pos, result_valid && last |-> position == 4'hf, "last on wrong position")

endmodule
`default_nettype wire

>>> hdl/mi4_mul.sv
`default_nettype none
module mi4_mul #(
  parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [mi4_pkg::acc_width(ELEMENT_WIDTH)-1:0] mcand_in,
  input  wire logic signed [ELEMENT_WIDTH-1:0] mplr_in,
  output logic busy,
  output logic done,
  output logic [mi4_pkg::acc_width(ELEMENT_WIDTH)-1:0] prod
);
  import mi4_pkg::*;

  localparam int AW  = acc_width(ELEMENT_WIDTH);
  localparam int DIG = (ELEMENT_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MW  = DIG * DIGIT_BITS;
  localparam int CW  = $clog2(DIG + 1);

  logic signed [AW-1:0] mcand;
  logic [MW-1:0] mplr_sh;
  logic [CW-1:0] cnt;
  logic first;
  logic [DIGIT_BITS-1:0] digit;
  logic signed [DIGIT_BITS:0] dsig;
  logic signed [AW+DIGIT_BITS:0] pp;
  logic [AW-1:0] prod_next;

  // horner over digits, most significant digit first and signed
  always_comb begin
    digit = mplr_sh[MW-1 -: DIGIT_BITS];
    dsig = first ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};
    pp = mcand * dsig;
    prod_next = {prod[AW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}} + pp[AW-1:0];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      mcand <= mcand_in;
      mplr_sh <= MW'(mplr_in);
      prod <= '0;
      cnt <= CW'(DIG);
      first <= 1'b1;
      busy <= 1'b1;
    end else if (busy) begin
      prod <= prod_next;
      mplr_sh <= mplr_sh << DIGIT_BITS;
      first <= 1'b0;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/mi4_div.sv
`default_nettype none
module mi4_div #(
  parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [mi4_pkg::acc_width(ELEMENT_WIDTH)-1:0] num_mag,
  input  wire logic [mi4_pkg::acc_width(ELEMENT_WIDTH)-1:0] den_mag,
  output logic done,
  output logic [ELEMENT_WIDTH:0] quot,
  output logic quot_big
);
  import mi4_pkg::*;

  localparam int AW = acc_width(ELEMENT_WIDTH);
  localparam int NB = AW + 2 * FRACTION_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] num_sh;
  logic [AW-1:0] rem;
  logic [AW-1:0] den;
  logic [CW-1:0] cnt;
  logic busy;
  logic [AW:0] trial;
  logic [AW:0] diff;
  logic ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem, num_sh[NB-1]};
    diff = trial - {1'b0, den};
    ge = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      num_sh <= {num_mag, {(2 * FRACTION_BITS){1'b0}}};
      den <= den_mag;
      rem <= '0;
      quot <= '0;
      quot_big <= 1'b0;
      cnt <= CW'(NB);
      busy <= 1'b1;
    end else if (busy) begin
      rem <= ge ? diff[AW-1:0] : trial[AW-1:0];
      quot <= {quot[ELEMENT_WIDTH-1:0], ge};
      // sticky flag for quotient bits beyond the kept window
      quot_big <= quot_big | quot[ELEMENT_WIDTH];
      num_sh <= num_sh << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
